>>> sv/acu_pkg.sv
// Shared types for the ARGB compositing unit: opcodes and the words that
// travel between pipeline stages. No dependencies.
package acu_pkg;

    localparam int LANES     = 4;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = LANES * CHAN_W;
    localparam int PROD_W    = 2 * CHAN_W;
    localparam int SUM_W     = CHAN_W + 1;
    localparam logic [PROD_W-1:0] HALF_UNIT = PROD_W'(128);
    localparam logic [CHAN_W-1:0] MAX_CHAN  = CHAN_W'(255);

    typedef enum logic [1:0] {
        OP_IN         = 2'd0,
        OP_OVER       = 2'd1,
        OP_OVER_ALPHA = 2'd2,
        OP_ADD        = 2'd3
    } t_op;

    // Stage 1 word: per-lane operands after selection
    typedef struct packed {
        t_op                           op;
        logic [LANES-1:0][CHAN_W-1:0]  d;
        logic [LANES-1:0][CHAN_W-1:0]  s;
        logic [LANES-1:0][CHAN_W-1:0]  f;
    } t_opnd;

    // Stage 2 word: per-lane products and raw sums
    typedef struct packed {
        t_op                           op;
        logic [LANES-1:0][PROD_W-1:0]  prod;
        logic [LANES-1:0][SUM_W-1:0]   sum;
    } t_prod;

endpackage

>>> sv/acu_operand.sv
// Stage 1: splits the pixels into lanes and picks the multiplier factor per
// operation. Depends on acu_pkg.
module acu_operand
    import acu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_op               i_op,
    input  logic [PIX_W-1:0]  i_first,
    input  logic [PIX_W-1:0]  i_second,
    output logic              o_valid,
    input  logic              i_ready,
    output t_opnd             o_data
);

    logic  r_valid;
    t_opnd r_data;
    t_opnd n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Operand selection
    always_comb begin
        n_data.op = i_op;
        for (int i = 0; i < LANES; i++) begin
            n_data.d[i] = i_first[i*CHAN_W +: CHAN_W];
            n_data.s[i] = i_second[i*CHAN_W +: CHAN_W];
            case (i_op)
                OP_IN:   n_data.f[i] = i_second[CHAN_W-1:0];
                OP_OVER: n_data.f[i] = i_second[PIX_W-1 -: CHAN_W];
                OP_OVER_ALPHA: begin
                    // single byte in lane 0; other lanes zero give zero
                    if (i == 0) begin
                        n_data.f[i] = i_second[CHAN_W-1:0];
                    end else begin
                        n_data.d[i] = '0;
                        n_data.s[i] = '0;
                        n_data.f[i] = '0;
                    end
                end
                default: n_data.f[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

>>> sv/acu_mul.sv
// Stage 2: 8x8 product and 9-bit sum in each lane. Depends on acu_pkg.
module acu_mul
    import acu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_opnd  i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_prod  o_data
);

    logic  r_valid;
    t_prod r_data;
    t_prod n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Lane multiply and add
    always_comb begin
        n_data.op = i_data.op;
        for (int i = 0; i < LANES; i++) begin
            n_data.prod[i] = PROD_W'(i_data.d[i]) * PROD_W'(i_data.f[i]);
            n_data.sum[i]  = SUM_W'(i_data.d[i]) + SUM_W'(i_data.s[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

>>> sv/acu_finish.sv
// Stage 3: rounded divide by 255 and per-operation result, held in the
// output register. Depends on acu_pkg.
module acu_finish
    import acu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_prod             i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PIX_W-1:0]  o_pixel
);

    logic             r_valid;
    logic [PIX_W-1:0] r_pixel;
    logic [PIX_W-1:0] n_pixel;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

    // q = (t + (t >> 8)) >> 8 with t = x + 128; fits 16 bits for 8x8 products
    always_comb begin
        logic [PROD_W-1:0] t;
        logic [PROD_W-1:0] u;
        logic [CHAN_W-1:0] q;
        logic [SUM_W-1:0]  diff;
        n_pixel = '0;
        for (int i = 0; i < LANES; i++) begin
            t    = i_data.prod[i] + HALF_UNIT;
            u    = t + (t >> CHAN_W);
            q    = u[PROD_W-1:CHAN_W];
            diff = i_data.sum[i] - SUM_W'(q);
            case (i_data.op) inside
                OP_IN:                 n_pixel[i*CHAN_W +: CHAN_W] = q;
                OP_OVER, OP_OVER_ALPHA: n_pixel[i*CHAN_W +: CHAN_W] = diff[CHAN_W-1:0];
                default: begin
                    // saturating add
                    if (i_data.sum[i][CHAN_W]) begin
                        n_pixel[i*CHAN_W +: CHAN_W] = MAX_CHAN;
                    end else begin
                        n_pixel[i*CHAN_W +: CHAN_W] = i_data.sum[i][CHAN_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixel <= n_pixel;
        end
    end

endmodule

>>> sv/argb_compositing_unit_core.sv
// ARGB8888 compositing unit, top level: three-stage pipeline built from
// acu_operand, acu_mul and acu_finish. Depends on acu_pkg.
//
// Usage:
//   Input channel i_valid / o_ready carries one word: i_req_type (in, over,
//   over_alpha, add), i_first_pixel and i_second_pixel. Output channel
//   o_valid / i_ready carries o_result_pixel, one result per input word,
//   in order.
//   Each word passes through three register stages (operand select, lane
//   multiply, rounded divide and result select) on its way to o_valid.
//   Throughput: one word per cycle while i_ready stays high; each stage
//   holds one word and the lane multipliers sit in their own stage.
//   Stalls: each stage has its own valid bit and loads when it is empty or
//   its successor takes its word, so a stalled receiver fills the pipe
//   up to three words before o_ready falls. Nothing is dropped or repeated.
//   Reset (i_rst_n low, synchronous) empties all stages; there is no
//   other state.
module argb_compositing_unit_core
    import acu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_req_type,
    input  logic [PIX_W-1:0]  i_first_pixel,
    input  logic [PIX_W-1:0]  i_second_pixel,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PIX_W-1:0]  o_result_pixel
);

    logic  s1_valid, s1_ready;
    logic  s2_valid, s2_ready;
    t_opnd s1_data;
    t_prod s2_data;

    // Stage 1: operand select
    acu_operand u_operand (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_op     (t_op'(i_req_type)),
        .i_first  (i_first_pixel),
        .i_second (i_second_pixel),
        .o_valid  (s1_valid),
        .i_ready  (s1_ready),
        .o_data   (s1_data)
    );

    // Stage 2: multiply
    acu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    // Stage 3: divide and result
    acu_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pixel (o_result_pixel)
    );

    // Empty output stage means the whole chain can take a word
    a_empty_out_ready : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready
    ) else $error("input not ready with output stage empty");

    // Backpressure only when every stage is full and the receiver stalls
    a_full_stall : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (s1_valid && s2_valid && o_valid && !i_ready)
    ) else $error("input stalled while pipeline has room");

    // A word in stage 2 stays there while stage 3 cannot take it
    a_s2_hold : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s2_valid && !s2_ready) |=> s2_valid
    ) else $error("stage 2 word lost during stall");

endmodule

>>> tb/argb_compositing_unit_core_tb.sv
// Self-checking testbench for argb_compositing_unit_core: random and directed
// pixel words with idling on both sides, checked against a built-in predictor.
// Depends on acu_pkg and the argb_compositing_unit_core RTL.
`timescale 1ns / 100ps

module argb_compositing_unit_core_tb;
    import acu_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_WORDS   = 900;

    // One word queued for the driver, with its lead-in gap
    typedef struct {
        t_op                op;
        logic [PIX_W-1:0]   first;
        logic [PIX_W-1:0]   second;
        int unsigned        gap;
        bit                 drain;
    } t_blend_req;

    // One predicted result, with the inputs that produced it
    typedef struct {
        t_op                op;
        logic [PIX_W-1:0]   first;
        logic [PIX_W-1:0]   second;
        logic [PIX_W-1:0]   pixel;
    } t_blend_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_req_type = 2'b00;
    logic [PIX_W-1:0]   i_first_pixel = '0;
    logic [PIX_W-1:0]   i_second_pixel = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [PIX_W-1:0]   o_result_pixel;

    t_blend_req  pending_words[$];
    t_blend_res  expected_pixels[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;

    // Driver-side word in flight
    t_blend_req  staged_word;
    bit          word_staged = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;

    argb_compositing_unit_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_first_pixel  (i_first_pixel),
        .i_second_pixel (i_second_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_pixel (o_result_pixel)
    );

    // Rounded divide by 255: (t + (t >> 8)) >> 8 with t = x + 128
    function automatic logic [CHAN_W-1:0] div255_round(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {1'b0, HALF_UNIT};
        return CHAN_W'((t + (t >> CHAN_W)) >> CHAN_W);
    endfunction

    // Over on one channel; the sum wraps to 8 bits
    function automatic logic [CHAN_W-1:0] over_lane(input logic [CHAN_W-1:0] d,
                                                    input logic [CHAN_W-1:0] s,
                                                    input logic [CHAN_W-1:0] sa);
        logic [CHAN_W-1:0] q;
        q = div255_round(PROD_W'(d) * PROD_W'(sa));
        return d + s - q;
    endfunction

    function automatic logic [PIX_W-1:0] composite_pixel(input t_op op,
                                                         input logic [PIX_W-1:0] first,
                                                         input logic [PIX_W-1:0] second);
        logic [PIX_W-1:0]  r;
        logic [CHAN_W-1:0] d;
        logic [CHAN_W-1:0] s;
        logic [CHAN_W:0]   sum;
        r = '0;
        if (op == OP_OVER_ALPHA) begin
            r[CHAN_W-1:0] = over_lane(first[CHAN_W-1:0], second[CHAN_W-1:0],
                                      second[CHAN_W-1:0]);
        end else begin
            for (int lane = 0; lane < LANES; lane++) begin
                d = first[lane*CHAN_W +: CHAN_W];
                s = second[lane*CHAN_W +: CHAN_W];
                case (op)
                    OP_IN: begin
                        r[lane*CHAN_W +: CHAN_W] =
                            div255_round(PROD_W'(d) * PROD_W'(second[CHAN_W-1:0]));
                    end
                    OP_OVER: begin
                        r[lane*CHAN_W +: CHAN_W] =
                            over_lane(d, s, second[PIX_W-1 -: CHAN_W]);
                    end
                    default: begin
                        sum = {1'b0, d} + {1'b0, s};
                        r[lane*CHAN_W +: CHAN_W] =
                            (sum > {1'b0, MAX_CHAN}) ? MAX_CHAN : sum[CHAN_W-1:0];
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Channels lean toward 0x00 and 0xff so saturation and wrap get hit often
    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        for (int lane = 0; lane < LANES; lane++) begin
            case ($urandom_range(0, 3))
                0:       p[lane*CHAN_W +: CHAN_W] = '0;
                1:       p[lane*CHAN_W +: CHAN_W] = MAX_CHAN;
                default: p[lane*CHAN_W +: CHAN_W] = CHAN_W'($urandom);
            endcase
        end
        return p;
    endfunction

    task automatic queue_word(input t_op op, input logic [PIX_W-1:0] first,
                              input logic [PIX_W-1:0] second, input int unsigned gap,
                              input bit drain);
        t_blend_req w;
        w.op = op;
        w.first = first;
        w.second = second;
        w.gap = gap;
        w.drain = drain;
        pending_words.push_back(w);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Driver: records accepted words, then presents the next one after its gap
    always @(posedge i_clk) begin : driver
        bit go;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_pixels.push_back('{op: t_op'(i_req_type),
                                            first: i_first_pixel,
                                            second: i_second_pixel,
                                            pixel: composite_pixel(t_op'(i_req_type),
                                                                   i_first_pixel,
                                                                   i_second_pixel)});
            end
            if (!(i_valid && !o_ready)) begin
                go = 1'b0;
                if (!word_staged && pending_words.size() != 0) begin
                    staged_word = pending_words.pop_front();
                    word_staged = 1'b1;
                    gap_left = staged_word.gap;
                end
                if (word_staged) begin
                    if (gap_left > 0)
                        gap_left--;
                    else if (!(staged_word.drain && expected_pixels.size() != 0))
                        go = 1'b1;
                end
                if (go) begin
                    i_valid        <= 1'b1;
                    i_req_type     <= staged_word.op;
                    i_first_pixel  <= staged_word.first;
                    i_second_pixel <= staged_word.second;
                    word_staged = 1'b0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word, stalls in alternating stretches
    always @(posedge i_clk) begin : monitor
        t_blend_res want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("result word %08h with nothing expected",
                                              o_result_pixel));
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_result_pixel !== want.pixel)
                        report_mismatch($sformatf(
                            "result_pixel %08h, want %08h (op %s first %08h second %08h)",
                            o_result_pixel, want.pixel, want.op.name(),
                            want.first, want.second));
                end
                results_seen++;
                stall_left = (results_seen % 128 < 64) ? $urandom_range(0, 16) : 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [PIX_W-1:0]  first;
        logic [PIX_W-1:0]  second;
        logic [CHAN_W-1:0] alpha;
        t_op               op;
        int unsigned       gap;

        // Every operation on all-zero and all-one operands
        for (int k = 0; k < 4; k++) begin
            op = t_op'(k);
            queue_word(op, '0, '0, $urandom_range(0, 16), 1'b0);
            queue_word(op, '1, '1, $urandom_range(0, 16), 1'b0);
            queue_word(op, '0, '1, $urandom_range(0, 16), 1'b0);
            queue_word(op, '1, '0, $urandom_range(0, 16), 1'b0);
        end
        // in: mask only from the low byte, upper bits junk
        queue_word(OP_IN, 32'h80ff0001, 32'habcdef80, 0, 1'b0);
        queue_word(OP_IN, 32'h12345678, 32'hffffff00, 0, 1'b0);
        // over: opaque and transparent premultiplied sources
        queue_word(OP_OVER, 32'h40804020, 32'hff102030, 0, 1'b0);
        queue_word(OP_OVER, 32'h40804020, 32'h00000000, 0, 1'b0);
        // over: source channels above alpha wrap instead of saturating
        queue_word(OP_OVER, 32'h00ffffff, 32'h00ffffff, 0, 1'b0);
        // over_alpha: upper bits of both pixels ignored
        queue_word(OP_OVER_ALPHA, 32'ha5a5a512, 32'h5a5a5a34, 0, 1'b0);
        // add: carries right at and just under saturation
        queue_word(OP_ADD, 32'h80808080, 32'h80808080, 0, 1'b0);
        queue_word(OP_ADD, 32'h7f7f7f7f, 32'h80808080, 0, 1'b0);
        queue_word(OP_ADD, 32'h01020304, 32'h10203040, 0, 1'b0);

        // Random words, bursts every third stretch, drain pauses along the way
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            op = t_op'($urandom_range(0, 3));
            first = rand_pixel();
            second = rand_pixel();
            if (op == OP_OVER && $urandom_range(0, 1) == 1) begin
                alpha = second[PIX_W-1 -: CHAN_W];
                for (int lane = 0; lane < LANES - 1; lane++)
                    second[lane*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(0, alpha));
            end
            gap = ((n / 150) % 3 == 1) ? 0 : $urandom_range(0, 16);
            queue_word(op, first, second, gap, (n % 300) == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || word_staged || i_valid ||
               expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
sv/acu_pkg.sv
sv/acu_operand.sv
sv/acu_mul.sv
sv/acu_finish.sv
sv/argb_compositing_unit_core.sv
tb/argb_compositing_unit_core_tb.sv
